// ===== design/pvs_pkg.sv =====
// ----------------------------------------------------------------------------
// pvs_pkg: shared constants and tables for the polyphonic voice synth
// Holds default parameters, register reset values, opcode constants and the
// small constant tables (velocity scaling, note split, increments, sine
// polynomial coefficients).
// ----------------------------------------------------------------------------
package pvs_pkg;

	// Default parameter values.
	localparam int VOICE_COUNT_DEF = 20;
	localparam int PHASE_BITS_DEF = 24;
	localparam int SINE_DEPTH_DEF = 1024;

	// Register reset values.
	localparam logic [15:0] GAIN_RESET = 16'd131;
	localparam logic [14:0] THR_RESET = 15'd16;

	// Register indexes on the configuration port.
	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_THR = 1'b1;

	// Input word opcodes.
	localparam logic [1:0] MODE_NOTE_ON = 2'd0;
	localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
	localparam logic [1:0] MODE_TICK = 2'd2;

	// Leading Horner coefficient of the odd sine polynomial, Q30.
	localparam logic [31:0] HORNER_C0 = 32'd172272;

	typedef struct packed {
		logic [3:0] oct;
		logic [3:0] semi;
	} note_pos_t;

	// Remaining Horner coefficients, applied in order.
	function automatic logic [31:0] horner_coef(input logic [1:0] k);
		logic [31:0] c;
		unique case (k)
			2'd0: c = 32'd5026997;
			2'd1: c = 32'd85569306;
			2'd2: c = 32'd693598669;
			default: c = 32'd1686629713;
		endcase
		return c;
	endfunction

	// Target amplitude for a velocity: round(v * 32767 / 127).
	function automatic logic [14:0] vel_target(input logic [6:0] v);
		logic [14:0] r;
		r = '0;
		for (int i = 0; i < 128; i++) begin
			if (v == 7'(i)) begin
				r = 15'((i * 32767 + 63) / 127);
			end
		end
		return r;
	endfunction

	// Octave and semitone of a note number.
	function automatic note_pos_t note_split(input logic [6:0] n);
		note_pos_t r;
		r = '0;
		for (int i = 0; i < 128; i++) begin
			if (n == 7'(i)) begin
				r.oct = 4'(i / 12);
				r.semi = 4'(i % 12);
			end
		end
		return r;
	endfunction

	// Phase increments of the top octave at 32 phase bits.
	function automatic logic [30:0] top_inc(input logic [3:0] semi);
		logic [30:0] t;
		unique case (semi)
			4'd0: t = 31'd898938597;
			4'd1: t = 31'd952392268;
			4'd2: t = 31'd1009024459;
			4'd3: t = 31'd1069024176;
			4'd4: t = 31'd1132591661;
			4'd5: t = 31'd1199939067;
			4'd6: t = 31'd1271291157;
			4'd7: t = 31'd1346886062;
			4'd8: t = 31'd1426976075;
			4'd9: t = 31'd1511828488;
			4'd10: t = 31'd1601726488;
			4'd11: t = 31'd1696970101;
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ===== design/pvs_ram.sv =====
// ----------------------------------------------------------------------------
// pvs_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/polyphonic_voice_synth_unit.sv =====
// ----------------------------------------------------------------------------
// polyphonic_voice_synth_unit: voice bank with voice stealing and additive mix
// Note-on, note-off and sample-tick words drive a sequencer that walks the
// voice RAM and runs all multiplications through one shared signed multiplier.
//
//   channel  direction  signals                                   word
//   in       sink       in_valid in_ready mode note velocity      command
//                       start_phase
//   out      source     out_valid out_ready sample                mixed sample
//   cfg      APB slave  psel penable pwrite paddr pwdata prdata   register
//                       pready
//
// A note-on and a note-off each scan every voice; a note-on then writes one.
// A tick skips free voices, stops early on a voice freed on that tick, and runs
// each sounding voice step by step through the shared multiplier.
// Reset frees all voices and loads the register defaults; the RAM is not cleared.
// A finished sample waits in the output register; a tick that completes while
// it is still held waits for it to be taken.
// ----------------------------------------------------------------------------
module polyphonic_voice_synth_unit
	import pvs_pkg::*;
#(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [6:0]         note,
	input  logic [6:0]         velocity,
	input  logic [23:0]        start_phase,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int LD = $clog2(SINE_TABLE_DEPTH);
	localparam int PB = PHASE_BITS;
	localparam int WW = 7 + PB + 30;
	localparam int ACCW = 35 + IW;
	localparam logic [IW-1:0] LAST_IDX = IW'(VOICE_COUNT - 1);

	typedef enum logic [18:0] {
		ST_IDLE      = 19'h00001,
		ST_ON_RD     = 19'h00002,
		ST_ON_CHK    = 19'h00004,
		ST_ON_WR     = 19'h00008,
		ST_OFF_RD    = 19'h00010,
		ST_OFF_CHK   = 19'h00020,
		ST_TK_RD     = 19'h00040,
		ST_TK_SMOOTH = 19'h00080,
		ST_TK_AMP    = 19'h00100,
		ST_TK_FOLD   = 19'h00200,
		ST_TK_Z2     = 19'h00400,
		ST_TK_HINIT  = 19'h00800,
		ST_TK_HMUL   = 19'h01000,
		ST_TK_HSUB   = 19'h02000,
		ST_TK_RES    = 19'h04000,
		ST_TK_SIN    = 19'h08000,
		ST_TK_MIX    = 19'h10000,
		ST_TK_ACC    = 19'h20000,
		ST_TK_DONE   = 19'h40000
	} state_t;

	state_t state_q;
	logic [IW-1:0] idx_q;
	logic [VOICE_COUNT-1:0] active_q;
	logic [15:0] gain_q;
	logic [14:0] thr_q;

	// Latched command word.
	logic [6:0] cmd_note_q;
	logic [14:0] cmd_tgt_q;
	logic [PB-1:0] cmd_phase_q;

	// Note-on scan results.
	logic match_q, free_q, min_q;
	logic [IW-1:0] match_idx_q, free_idx_q, min_idx_q;
	logic [PB-1:0] match_phase_q;
	logic [14:0] match_amp_q, min_amp_q;

	// Per-voice tick working registers.
	logic [6:0] v_note_q;
	logic [PB-1:0] v_phase_q;
	logic [14:0] v_amp_q, v_tgt_q;
	logic [1:0] harm_q, hk_q;
	logic [30:0] z_q, z2_q;
	logic neg_q;
	logic [31:0] hp_q;
	logic signed [18:0] h_q;
	logic signed [ACCW-1:0] acc_q;
	logic signed [63:0] prod_q;
	logic signed [15:0] sample_q;
	logic out_valid_q;

	// RAM word fields.
	logic [WW-1:0] rd_data, wr_data;
	logic wr_en;
	logic [IW-1:0] wr_addr;
	logic [6:0] rd_note;
	logic [PB-1:0] rd_phase;
	logic [14:0] rd_amp, rd_tgt;

	assign rd_note = rd_data[WW-1 -: 7];
	assign rd_phase = rd_data[30 +: PB];
	assign rd_amp = rd_data[29:15];
	assign rd_tgt = rd_data[14:0];

	pvs_ram #(
		.WIDTH (WW),
		.DEPTH (VOICE_COUNT)
	) u_voice_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (idx_q),
		.rdata (rd_data)
	);

	// Handshake and configuration port.
	logic in_fire, cfg_wr, last_voice;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THR) ? {17'd0, thr_q} : {16'd0, gain_q};
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign last_voice = (idx_q == LAST_IDX);

	// Start phase mapped onto the phase width.
	logic [PB-1:0] mapped_phase;
	always_comb begin
		if (PB >= 24) begin
			mapped_phase = PB'({8'd0, start_phase} << (PB - 24));
		end else begin
			mapped_phase = PB'(start_phase >> (24 - PB));
		end
	end

	// Shared signed multiplier; operands chosen by the sequencer step.
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_p;
	logic signed [15:0] diff;
	assign diff = $signed({1'b0, rd_tgt}) - $signed({1'b0, rd_amp});
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_TK_SMOOTH: begin
				mul_a = 33'(diff);
				mul_b = $signed({17'd0, gain_q});
			end
			ST_TK_Z2: begin
				mul_a = $signed({2'b0, z_q});
				mul_b = $signed({2'b0, z_q});
			end
			ST_TK_HMUL: begin
				mul_a = $signed({2'b0, z2_q});
				mul_b = $signed({1'b0, hp_q});
			end
			ST_TK_RES: begin
				mul_a = $signed({2'b0, z_q});
				mul_b = $signed({1'b0, hp_q});
			end
			ST_TK_MIX: begin
				mul_a = 33'(h_q);
				mul_b = $signed({18'd0, v_amp_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// Smoothing step and release check.
	logic [16:0] amp_sum;
	logic [14:0] amp_new;
	logic freed;
	assign amp_sum = {2'b00, v_amp_q} + prod_q[32:16];
	assign amp_new = amp_sum[14:0];
	assign freed = (amp_new < thr_q) && (v_tgt_q == '0);

	// Quadrant folding of the harmonic phase.
	logic [PB-1:0] arg;
	logic [LD-1:0] k_idx;
	logic [LD:0] r_w;
	logic [30:0] z_w;
	always_comb begin
		unique case (harm_q)
			2'd0: arg = v_phase_q;
			2'd1: arg = v_phase_q << 1;
			default: arg = v_phase_q + (v_phase_q << 1);
		endcase
		k_idx = arg[PB-1 -: LD];
		r_w = {1'b0, k_idx[LD-3:0], 2'b00};
		if (k_idx[LD-2]) begin
			r_w = (LD + 1)'(SINE_TABLE_DEPTH) - r_w;
		end
		z_w = 31'(r_w) << (30 - LD);
	end

	// Sine rounding, clamp, sign and harmonic weight.
	logic [31:0] res;
	logic [17:0] s_round;
	logic [15:0] s_mag;
	logic signed [18:0] s_val, s_wt;
	always_comb begin
		res = prod_q[61:30];
		s_round = 18'((33'(res) + 33'd16384) >> 15);
		s_mag = (s_round > 18'd32767) ? 16'd32767 : s_round[15:0];
		s_val = neg_q ? -$signed({3'b0, s_mag}) : $signed({3'b0, s_mag});
		unique case (harm_q)
			2'd0: s_wt = s_val <<< 2;
			2'd1: s_wt = s_val <<< 1;
			default: s_wt = s_val;
		endcase
	end

	// Note increment with round half up.
	note_pos_t np;
	logic [5:0] inc_sh;
	logic [31:0] inc_tmp;
	logic [32:0] inc_rnd;
	logic [PB-1:0] inc;
	always_comb begin
		np = note_split(v_note_q);
		inc_sh = 6'(10 - int'(np.oct) + 32 - PB);
		inc_tmp = {top_inc(np.semi), 1'b0} >> inc_sh;
		inc_rnd = (33'(inc_tmp) + 33'd1) >> 1;
		inc = inc_rnd[PB-1:0];
	end

	// Output rounding and saturation.
	logic signed [ACCW-1:0] acc_r, acc_sh;
	logic signed [15:0] sat;
	always_comb begin
		acc_r = acc_q + ACCW'(65536);
		acc_sh = acc_r >>> 17;
		if (acc_sh > ACCW'(32767)) begin
			sat = 16'sd32767;
		end else if (acc_sh < -ACCW'(32767)) begin
			sat = -16'sd32767;
		end else begin
			sat = acc_sh[15:0];
		end
	end

	// RAM write port.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = idx_q;
		wr_data = {v_note_q, v_phase_q + inc, v_amp_q, v_tgt_q};
		unique case (state_q)
			ST_ON_WR: begin
				wr_en = 1'b1;
				if (match_q) begin
					wr_addr = match_idx_q;
					wr_data = {cmd_note_q, match_phase_q, match_amp_q, cmd_tgt_q};
				end else begin
					wr_addr = free_q ? free_idx_q : min_idx_q;
					wr_data = {cmd_note_q, cmd_phase_q, 15'd0, cmd_tgt_q};
				end
			end
			ST_OFF_CHK: begin
				wr_en = active_q[idx_q] && (rd_note == cmd_note_q);
				wr_data = {rd_note, rd_phase, rd_amp, 15'd0};
			end
			ST_TK_ACC: wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			active_q <= '0;
			gain_q <= GAIN_RESET;
			thr_q <= THR_RESET;
			out_valid_q <= 1'b0;
			match_q <= 1'b0;
			free_q <= 1'b0;
			min_q <= 1'b0;
			harm_q <= '0;
			hk_q <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_GAIN) begin
					gain_q <= pwdata[15:0];
				end else begin
					thr_q <= pwdata[14:0];
				end
			end
			// The completion step below owns the flag while a tick finishes.
			if (out_valid_q && out_ready && state_q != ST_TK_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						idx_q <= '0;
						match_q <= 1'b0;
						free_q <= 1'b0;
						min_q <= 1'b0;
						if (mode == MODE_NOTE_ON) begin
							state_q <= ST_ON_RD;
						end else if (mode == MODE_NOTE_OFF) begin
							state_q <= ST_OFF_RD;
						end else if (mode == MODE_TICK) begin
							state_q <= ST_TK_RD;
						end
					end
				end
				ST_ON_RD: state_q <= ST_ON_CHK;
				ST_ON_CHK: begin
					if (active_q[idx_q] && rd_note == cmd_note_q && !match_q) begin
						match_q <= 1'b1;
						match_idx_q <= idx_q;
					end
					if (!active_q[idx_q] && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (active_q[idx_q] && (!min_q || rd_amp < min_amp_q)) begin
						min_q <= 1'b1;
						min_idx_q <= idx_q;
					end
					if (last_voice) begin
						state_q <= ST_ON_WR;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_ON_RD;
					end
				end
				ST_ON_WR: begin
					if (!match_q) begin
						active_q[free_q ? free_idx_q : min_idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				ST_OFF_RD: state_q <= ST_OFF_CHK;
				ST_OFF_CHK: begin
					if (last_voice) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_OFF_RD;
					end
				end
				ST_TK_RD: begin
					if (active_q[idx_q]) begin
						state_q <= ST_TK_SMOOTH;
					end else if (last_voice) begin
						state_q <= ST_TK_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_TK_SMOOTH: state_q <= ST_TK_AMP;
				ST_TK_AMP: begin
					harm_q <= '0;
					if (freed) begin
						active_q[idx_q] <= 1'b0;
						if (last_voice) begin
							state_q <= ST_TK_DONE;
						end else begin
							idx_q <= idx_q + 1'b1;
							state_q <= ST_TK_RD;
						end
					end else begin
						state_q <= ST_TK_FOLD;
					end
				end
				ST_TK_FOLD: state_q <= ST_TK_Z2;
				ST_TK_Z2: state_q <= ST_TK_HINIT;
				ST_TK_HINIT: begin
					hk_q <= '0;
					state_q <= ST_TK_HMUL;
				end
				ST_TK_HMUL: state_q <= ST_TK_HSUB;
				ST_TK_HSUB: begin
					hk_q <= hk_q + 1'b1;
					state_q <= (hk_q == 2'd3) ? ST_TK_RES : ST_TK_HMUL;
				end
				ST_TK_RES: state_q <= ST_TK_SIN;
				ST_TK_SIN: begin
					harm_q <= harm_q + 1'b1;
					state_q <= (harm_q == 2'd2) ? ST_TK_MIX : ST_TK_FOLD;
				end
				ST_TK_MIX: state_q <= ST_TK_ACC;
				ST_TK_ACC: begin
					if (last_voice) begin
						state_q <= ST_TK_DONE;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= ST_TK_RD;
					end
				end
				ST_TK_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		prod_q <= mul_p[63:0];
		if (in_fire) begin
			cmd_note_q <= note;
			cmd_tgt_q <= vel_target(velocity);
			cmd_phase_q <= mapped_phase;
			acc_q <= '0;
		end
		if (state_q == ST_ON_CHK) begin
			if (active_q[idx_q] && rd_note == cmd_note_q && !match_q) begin
				match_phase_q <= rd_phase;
				match_amp_q <= rd_amp;
			end
			if (active_q[idx_q] && (!min_q || rd_amp < min_amp_q)) begin
				min_amp_q <= rd_amp;
			end
		end
		if (state_q == ST_TK_SMOOTH) begin
			v_note_q <= rd_note;
			v_phase_q <= rd_phase;
			v_amp_q <= rd_amp;
			v_tgt_q <= rd_tgt;
		end
		if (state_q == ST_TK_AMP) begin
			v_amp_q <= amp_new;
		end
		if (state_q == ST_TK_FOLD) begin
			z_q <= z_w;
			neg_q <= k_idx[LD-1];
		end
		if (state_q == ST_TK_HINIT) begin
			z2_q <= prod_q[60:30];
			hp_q <= HORNER_C0;
		end
		if (state_q == ST_TK_HSUB) begin
			hp_q <= horner_coef(hk_q) - prod_q[61:30];
		end
		if (state_q == ST_TK_SIN) begin
			h_q <= ((harm_q == 2'd0) ? 19'sd0 : h_q) + s_wt;
		end
		if (state_q == ST_TK_ACC) begin
			acc_q <= acc_q + ACCW'($signed(prod_q[33:0]));
		end
		if (state_q == ST_TK_DONE && (!out_valid_q || out_ready)) begin
			sample_q <= sat;
		end
	end

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state is not one-hot");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr <= LAST_IDX))
		else $error("voice RAM write beyond the voice bank");

	a_tick_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && mode == MODE_TICK) |=> (state_q == ST_TK_RD))
		else $error("accepted tick did not start the voice walk");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_TK_DONE))
		else $error("sample produced outside tick completion");
`endif

endmodule

// ===== verif/voice_mix_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// voice_mix_checker: sample predictor and scoreboard for the voice synth
// Watches the command, sample and register channels. Keeps its own voice bank
// and mixer, works out the sample for each accepted tick, and compares every
// accepted sample word with the oldest expected one.
// ----------------------------------------------------------------------------
module voice_mix_checker
	import pvs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [6:0]         note,
	input  logic [6:0]         velocity,
	input  logic [23:0]        start_phase,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [15:0] sample,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic               pready,
	output int                 mismatch_count,
	output int                 samples_pending
);

	localparam int NV = VOICE_COUNT_DEF;
	localparam longint unsigned PMASK = 64'hFF_FFFF;

	// Predicted register and voice bank contents.
	logic [15:0] gain;
	logic [14:0] threshold;
	logic [6:0]  bank_note [NV];
	logic [23:0] bank_phase [NV];
	int          bank_amp [NV];
	int          bank_target [NV];
	bit          bank_busy [NV];

	logic signed [15:0] expected_samples [$];

	// Top-octave phase steps at 32 phase bits.
	longint unsigned octave_steps [12] = '{
		898938597, 952392268, 1009024459, 1069024176,
		1132591661, 1199939067, 1271291157, 1346886062,
		1426976075, 1511828488, 1601726488, 1696970101};

	// Quarter-wave folded sine of a 24-bit phase, Q15.
	function automatic longint harmonic_sine(input longint unsigned ph);
		longint unsigned k, m, q, r;
		longint z, z2, p, res, s;
		k = ((ph & PMASK) * 1024) >> 24;
		m = 4 * k;
		q = m / 1024;
		r = m % 1024;
		if (q[0]) r = 1024 - r;
		z = longint'((r << 30) / 1024);
		z2 = (z * z) >>> 30;
		p = 172272;
		p = 5026997 - ((z2 * p) >>> 30);
		p = 85569306 - ((z2 * p) >>> 30);
		p = 693598669 - ((z2 * p) >>> 30);
		p = 1686629713 - ((z2 * p) >>> 30);
		res = (z * p) >>> 30;
		s = (res + 16384) >>> 15;
		if (s > 32767) s = 32767;
		return (q >= 2) ? -s : s;
	endfunction

	// Phase step of a note, rounded half up from the top octave.
	function automatic longint unsigned note_step(input logic [6:0] n);
		int sh;
		sh = (10 - n / 12) + 8;
		return ((octave_steps[n % 12] + (64'd1 << (sh - 1))) >> sh) & PMASK;
	endfunction

	// One sample tick: smooth, free faded voices, mix, advance phases.
	function automatic logic signed [15:0] mix_tick();
		longint acc, prod, step, h, t, s;
		longint unsigned p;
		acc = 0;
		for (int i = 0; i < NV; i++) begin
			if (!bank_busy[i]) continue;
			prod = longint'(bank_target[i] - bank_amp[i]) * longint'(gain);
			step = (prod >= 0) ? (prod >>> 16) : -((-prod + 65535) >>> 16);
			bank_amp[i] += int'(step);
			if (bank_amp[i] < int'(threshold) && bank_target[i] == 0) begin
				bank_busy[i] = 1'b0;
				continue;
			end
			p = bank_phase[i];
			h = 4 * harmonic_sine(p) + 2 * harmonic_sine(2 * p) + harmonic_sine(3 * p);
			acc += h * bank_amp[i];
			bank_phase[i] = 24'((p + note_step(bank_note[i])) & PMASK);
		end
		t = acc + 65536;
		s = (t >= 0) ? (t >>> 17) : -((-t + 131071) >>> 17);
		if (s > 32767) s = 32767;
		if (s < -32767) s = -32767;
		return 16'(s);
	endfunction

	// Note-on: retarget a matching voice, else take a free one, else steal.
	function automatic void start_note(input logic [6:0] n, input logic [6:0] v,
			input logic [23:0] sp);
		int tgt, slot;
		tgt = (int'(v) * 32767 + 63) / 127;
		slot = -1;
		for (int i = 0; i < NV; i++) begin
			if (bank_busy[i] && bank_note[i] == n) begin
				bank_target[i] = tgt;
				return;
			end
		end
		for (int i = 0; i < NV; i++) begin
			if (!bank_busy[i] && slot < 0) slot = i;
		end
		if (slot < 0) begin
			slot = 0;
			for (int i = 1; i < NV; i++) begin
				if (bank_amp[i] < bank_amp[slot]) slot = i;
			end
		end
		bank_note[slot] = n;
		bank_phase[slot] = sp;
		bank_amp[slot] = 0;
		bank_target[slot] = tgt;
		bank_busy[slot] = 1'b1;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t: MISMATCH %s got %0d expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	initial mismatch_count = 0;

	// Channel monitor: updates the prediction and scores each sample word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = GAIN_RESET;
			threshold = THR_RESET;
			for (int i = 0; i < NV; i++) begin
				bank_amp[i] = 0;
				bank_target[i] = 0;
				bank_busy[i] = 1'b0;
			end
			expected_samples.delete();
			samples_pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == {REG_GAIN, 2'b00}) gain = pwdata[15:0];
				else if (paddr == {REG_THR, 2'b00}) threshold = pwdata[14:0];
			end
			if (in_valid && in_ready) begin
				case (mode)
					MODE_NOTE_ON: start_note(note, velocity, start_phase);
					MODE_NOTE_OFF: begin
						for (int i = 0; i < NV; i++) begin
							if (bank_busy[i] && bank_note[i] == note) bank_target[i] = 0;
						end
					end
					MODE_TICK: expected_samples.push_back(mix_tick());
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_samples.size() == 0) begin
					report("unexpected sample", sample, 0);
				end else begin
					logic signed [15:0] want;
					want = expected_samples.pop_front();
					if (sample !== want) report("sample", sample, want);
				end
			end
			samples_pending = expected_samples.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the polyphonic voice synth
// Plays note-on, note-off and tick words through several register settings
// with random gaps and output stalls, including one long output stall, while
// the checker predicts and scores every sample word.
// ----------------------------------------------------------------------------
module testbench;
	import pvs_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int PHASE_ITEMS = 390;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [6:0]         note;
	logic [6:0]         velocity;
	logic [23:0]        start_phase;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] sample;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	int                 mismatch_count;
	int                 samples_pending;
	logic [6:0]         note_pool [28];

	polyphonic_voice_synth_unit DUT (.*);

	voice_mix_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Send one command word after a random gap; valid stays up across gap-free words.
	task automatic send_word(input logic [1:0] m, input logic [6:0] n,
			input logic [6:0] v, input logic [23:0] sp);
		int gap;
		bit rdy;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		note <= n;
		velocity <= v;
		start_phase <= sp;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
	endtask

	// Register write through a setup and an access phase, block idle.
	task automatic write_reg(input logic idx, input logic [31:0] value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drain all samples, then let a possible note command finish.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (samples_pending == 0);
		repeat (1000) @(posedge clk);
	endtask

	function automatic logic [6:0] pick_note();
		return ($urandom_range(0, 9) < 7) ? note_pool[$urandom_range(0, 27)]
			: 7'($urandom_range(0, 127));
	endfunction

	task automatic random_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) send_word(MODE_NOTE_ON, pick_note(), 7'($urandom_range(0, 127)),
			24'($urandom));
		else if (r < 65) send_word(MODE_NOTE_OFF, pick_note(), 7'($urandom),
			24'($urandom));
		else if (r < 98) send_word(MODE_TICK, 7'($urandom), 7'($urandom), 24'($urandom));
		else send_word(MODE_UNUSED, pick_note(), 7'($urandom), 24'($urandom));
	endtask

	// Sample sink: random stalls per word, and one long hold-off.
	initial begin
		int taken;
		bit vld;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			if (taken == 150) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
			end else if ($urandom_range(0, 1)) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				vld = out_valid;
				@(posedge clk);
			end while (!vld);
			taken++;
		end
	end

	// Main stimulus.
	initial begin
		in_valid <= 1'b0;
		mode <= MODE_TICK;
		note <= '0;
		velocity <= '0;
		start_phase <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, retarget, unmatched release, unused mode.
		send_word(MODE_NOTE_ON, 7'd0, 7'd127, 24'h000000);
		send_word(MODE_NOTE_ON, 7'd127, 7'd0, 24'hFFFFFF);
		send_word(MODE_TICK, 7'd0, 7'd0, 24'd0);
		send_word(MODE_NOTE_OFF, 7'd50, 7'd0, 24'd0);
		send_word(MODE_UNUSED, 7'd127, 7'd127, 24'hFFFFFF);
		send_word(MODE_TICK, 7'd127, 7'd127, 24'hFFFFFF);
		send_word(MODE_NOTE_ON, 7'd0, 7'd64, 24'h555555);
		send_word(MODE_NOTE_ON, 7'd69, 7'd100, 24'hAAAAAA);
		send_word(MODE_TICK, 7'd0, 7'd0, 24'd0);
		send_word(MODE_NOTE_OFF, 7'd0, 7'd0, 24'd0);
		send_word(MODE_TICK, 7'd0, 7'd0, 24'd0);
		send_word(MODE_TICK, 7'd0, 7'd0, 24'd0);
		settle();

		// Random phases over several register settings.
		for (int ph = 0; ph < 5; ph++) begin
			for (int i = 0; i < 28; i++) note_pool[i] = 7'($urandom_range(0, 127));
			case (ph)
				1: begin
					write_reg(REG_GAIN, 32'd65535);
					write_reg(REG_THR, 32'd32767);
				end
				2: begin
					write_reg(REG_GAIN, 32'd0);
					write_reg(REG_THR, 32'd0);
				end
				3: begin
					write_reg(REG_GAIN, 32'd4000);
					write_reg(REG_THR, 32'd200);
				end
				4: begin
					write_reg(REG_GAIN, $urandom_range(0, 65535));
					write_reg(REG_THR, $urandom_range(0, 32767));
				end
				default: ;
			endcase
			// Fill more than the voice bank so that stealing happens.
			for (int i = 0; i < 24; i++)
				send_word(MODE_NOTE_ON, note_pool[i], 7'($urandom_range(0, 127)),
					24'($urandom));
			for (int i = 0; i < PHASE_ITEMS - 24; i++) random_word();
			settle();
		end

		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#100_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
